>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checker assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker assertion failed");

`endif

>>> rtl/core/rrs_pkg.sv
package rrs_pkg;

    // Request modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SCORE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] LAST_VIEW = 2'd3;

    // Sequencer lengths
    localparam logic [4:0] LAST_STEP = 5'd18;
    localparam logic [5:0] DIV_LAST  = 6'd47;

    // Saturation limits and threshold reset value
    localparam logic [39:0] RES_MAX   = {40{1'b1}};
    localparam logic [47:0] SCORE_MAX = {48{1'b1}};
    localparam logic [31:0] MAX_ERR_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_SCORE
    } t_state;

endpackage

>>> rtl/core/radial_reprojection_scorer.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------
// input     | in        | i_in_valid / o_in_ready    | mode, view, row, coef0..3,
//           |           |                            | point_x/y/z, obs_u/v
// result    | out       | o_out_valid / i_out_ready  | inlier, cheirality, residual,
//           |           |                            | total score, inlier count
// config    | in        | i_cfg_valid / o_cfg_ready  | error threshold
//
// Load, clear and unused-mode requests finish in the accepting cycle.
// A score request holds input not ready until it is done, so the block takes no new
// request before the last one is through: 19 steps of the shared 33x33 multiplier,
// 48 steps of the one-bit-per-cycle restoring divider (skipped when the projection is
// zero) and an accumulate step. A view 3 request adds a scoring state, which stalls
// while the output register is full and not being read. Reset is synchronous, low.
module radial_reprojection_scorer #(
    parameter int MAX_POINTS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // input requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_view,
    input  logic        i_row,
    input  logic signed [31:0] i_coef0,
    input  logic signed [31:0] i_coef1,
    input  logic signed [31:0] i_coef2,
    input  logic signed [31:0] i_coef3,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_obs_u,
    input  logic signed [31:0] i_obs_v,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_point_inlier,
    output logic        o_cheirality_fail,
    output logic [39:0] o_point_residual,
    output logic [47:0] o_total_score,
    output logic [16:0] o_inlier_total
);
    import rrs_pkg::*;

    localparam int CNT_LIM_INT = (MAX_POINTS < 131071) ? MAX_POINTS : 131071;
    localparam logic [16:0] CNT_LIM = 17'(CNT_LIM_INT);

    t_state r_state, n_state;

    // Camera store: one 256-bit entry per view, one 128-bit half per row
    logic [255:0] r_cam_store [4];
    logic [255:0] r_cam;

    logic [31:0]        r_max_err;
    logic [1:0]         r_view;
    logic signed [31:0] r_x, r_y, r_z, r_u, r_v;
    logic [4:0]         r_step;
    logic [5:0]         r_dcnt;

    logic signed [65:0] r_prod;
    logic signed [97:0] r_acc;
    logic signed [31:0] r_pu, r_pv;
    logic [63:0]        r_pp, r_absc, r_xx, r_rem;
    logic [47:0]        r_thr, r_num;
    logic               r_neg;

    logic [39:0] r_part;
    logic        r_ok, r_bad;
    logic [47:0] r_score;
    logic [16:0] r_cnt;

    logic        r_out_valid, r_out_inl, r_out_bad;
    logic [39:0] r_out_res;
    logic [47:0] r_out_score;
    logic [16:0] r_out_cnt;

    logic               w_in_acc;
    logic signed [32:0] w_ma, w_mb;
    logic signed [97:0] w_pext, w_sum, w_diff, w_proj;
    logic [65:0]        w_hi;
    logic [64:0]        w_trial;
    logic               w_ge;
    logic               w_view0;
    logic [48:0]        w_rsum;
    logic [39:0]        w_res_sat;
    logic               w_inl;
    logic [50:0]        w_ssum;
    logic [47:0]        w_score_sat;
    logic [16:0]        w_cnt_nxt;
    logic               w_emit;

    function automatic logic signed [31:0] sat32(input logic signed [97:0] v);
        if (v > 98'sd2147483647) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -98'sd2147483648) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid & o_in_ready;

    // Shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_step)
            5'd0:  begin w_ma = {r_cam[31],  r_cam[31:0]};    w_mb = {r_x[31], r_x}; end
            5'd1:  begin w_ma = {r_cam[63],  r_cam[63:32]};   w_mb = {r_y[31], r_y}; end
            5'd2:  begin w_ma = {r_cam[95],  r_cam[95:64]};   w_mb = {r_z[31], r_z}; end
            5'd3:  begin w_ma = {r_cam[159], r_cam[159:128]}; w_mb = {r_x[31], r_x}; end
            5'd4:  begin w_ma = {r_cam[191], r_cam[191:160]}; w_mb = {r_y[31], r_y}; end
            5'd5:  begin w_ma = {r_cam[223], r_cam[223:192]}; w_mb = {r_z[31], r_z}; end
            5'd6:  begin w_ma = {r_pu[31], r_pu}; w_mb = {r_pu[31], r_pu}; end
            5'd7:  begin w_ma = {r_pv[31], r_pv}; w_mb = {r_pv[31], r_pv}; end
            5'd8:  begin w_ma = {r_pu[31], r_pu}; w_mb = {r_u[31], r_u};   end
            5'd9:  begin w_ma = {r_pv[31], r_pv}; w_mb = {r_v[31], r_v};   end
            5'd10: begin w_ma = {r_pv[31], r_pv}; w_mb = {r_u[31], r_u};   end
            5'd11: begin w_ma = {r_pu[31], r_pu}; w_mb = {r_v[31], r_v};   end
            5'd12: begin w_ma = {r_u[31], r_u};   w_mb = {r_u[31], r_u};   end
            5'd13: begin w_ma = {r_v[31], r_v};   w_mb = {r_v[31], r_v};   end
            5'd14: begin w_ma = {1'b0, r_max_err}; w_mb = {1'b0, r_max_err}; end
            5'd15: begin w_ma = {1'b0, r_absc[31:0]};  w_mb = {1'b0, r_absc[31:0]};  end
            5'd16: begin w_ma = {1'b0, r_absc[31:0]};  w_mb = {1'b0, r_absc[63:32]}; end
            5'd17: begin w_ma = {1'b0, r_absc[63:32]}; w_mb = {1'b0, r_absc[63:32]}; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // Accumulate paths
    assign w_pext = {{32{r_prod[65]}}, r_prod};
    assign w_sum  = r_acc + w_pext;
    assign w_diff = r_acc - w_pext;
    assign w_proj = (w_sum >>> 16) +
        ((r_step == 5'd3) ? 98'(signed'(r_cam[127:96])) : 98'(signed'(r_cam[255:224])));
    assign w_hi   = {2'b00, r_acc[97:64]} + 66'(unsigned'(r_prod));

    // Restoring divide step
    assign w_trial = {r_rem, r_num[47]};
    assign w_ge    = (w_trial >= {1'b0, r_pp});

    // Point and score updates
    assign w_view0   = (r_view == 2'd0);
    assign w_rsum    = {9'd0, (w_view0 ? 40'd0 : r_part)} + {1'b0, r_num};
    assign w_res_sat = (w_rsum > {9'd0, RES_MAX}) ? RES_MAX : w_rsum[39:0];
    assign w_inl     = r_ok & ~r_bad;
    assign w_ssum    = {3'd0, r_score} +
                       (w_inl ? {11'd0, r_part} : {1'b0, r_thr, 2'b00});
    assign w_score_sat = (w_ssum > {3'd0, SCORE_MAX}) ? SCORE_MAX : w_ssum[47:0];
    assign w_cnt_nxt   = (w_inl && r_cnt < CNT_LIM) ? r_cnt + 17'd1 : r_cnt;
    assign w_emit    = (r_state == ST_SCORE) & (~r_out_valid | i_out_ready);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_mode == MODE_SCORE) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_step == LAST_STEP) n_state = (r_pp == 64'd0) ? ST_ACC : ST_DIV;
            end
            ST_DIV: begin
                if (r_dcnt == 6'd0) n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = (r_view == LAST_VIEW) ? ST_SCORE : ST_IDLE;
            end
            ST_SCORE: begin
                if (w_emit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Config, camera store and point/score state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err <= MAX_ERR_RESET;
            for (int i = 0; i < 4; i++) r_cam_store[i] <= '0;
            r_part  <= '0;
            r_ok    <= 1'b1;
            r_bad   <= 1'b0;
            r_score <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid) r_max_err <= i_cfg_data;
            if (w_in_acc && i_mode == MODE_LOAD) begin
                if (i_row) begin
                    r_cam_store[i_view][255:128] <= {i_coef3, i_coef2, i_coef1, i_coef0};
                end else begin
                    r_cam_store[i_view][127:0]   <= {i_coef3, i_coef2, i_coef1, i_coef0};
                end
            end
            if (w_in_acc && i_mode == MODE_CLEAR) begin
                r_score <= '0;
                r_cnt   <= '0;
                r_part  <= '0;
                r_ok    <= 1'b1;
                r_bad   <= 1'b0;
            end
            if (r_state == ST_ACC) begin
                r_part <= w_res_sat;
                r_ok   <= (w_view0 | r_ok) & (r_num < r_thr);
                r_bad  <= (~w_view0 & r_bad) | ((r_pp != 64'd0) & r_neg);
            end
            if (w_emit) begin
                r_score <= w_score_sat;
                r_cnt   <= w_cnt_nxt;
            end
        end
    end

    // Sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_dcnt <= '0;
        end else begin
            if (r_state == ST_IDLE) begin
                r_step <= '0;
            end else if (r_state == ST_MUL) begin
                r_step <= r_step + 5'd1;
            end
            if (r_state == ST_MUL) begin
                r_dcnt <= DIV_LAST;
            end else if (r_state == ST_DIV) begin
                r_dcnt <= r_dcnt - 6'd1;
            end
        end
    end

    // Datapath: latch request, multiply, accumulate, divide
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_mode == MODE_SCORE) begin
            r_cam  <= r_cam_store[i_view];
            r_view <= i_view;
            r_x    <= i_point_x;
            r_y    <= i_point_y;
            r_z    <= i_point_z;
            r_u    <= i_obs_u;
            r_v    <= i_obs_v;
        end
        r_prod <= w_ma * w_mb;
        if (r_state == ST_MUL) begin
            case (r_step)
                5'd1, 5'd4, 5'd7, 5'd9, 5'd11, 5'd13, 5'd16: r_acc <= w_pext;
                5'd2, 5'd5: r_acc <= w_sum;
                5'd3:  r_pu <= sat32(w_proj);
                5'd6:  r_pv <= sat32(w_proj);
                5'd8:  r_pp <= w_sum[63:0];
                5'd10: r_neg <= w_sum[97];
                5'd12: r_absc <= w_diff[97] ? 64'(-w_diff) : w_diff[63:0];
                5'd14: r_xx <= w_sum[63:0];
                5'd15: r_thr <= r_prod[63:16];
                5'd17: r_acc <= r_acc + (w_pext <<< 33);
                5'd18: begin
                    r_rem <= w_hi[63:0];
                    r_num <= (r_pp == 64'd0) ? r_xx[63:16] : r_acc[63:16];
                end
                default: ;
            endcase
        end
        if (r_state == ST_DIV) begin
            r_rem <= w_ge ? 64'(w_trial - {1'b0, r_pp}) : w_trial[63:0];
            r_num <= {r_num[46:0], w_ge};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, held while the result waits
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_inl   <= w_inl;
            r_out_bad   <= r_bad;
            r_out_res   <= r_part;
            r_out_score <= w_score_sat;
            r_out_cnt   <= w_cnt_nxt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_point_inlier    = r_out_inl;
    assign o_cheirality_fail = r_out_bad;
    assign o_point_residual  = r_out_res;
    assign o_total_score     = r_out_score;
    assign o_inlier_total    = r_out_cnt;

endmodule

>>> rtl/core/rrs_checker.sv
`include "assert_macros.svh"

module rrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_mode,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_point_inlier,
    input logic        o_cheirality_fail,
    input logic [47:0] o_total_score,
    input logic [16:0] o_inlier_total
);
    import rrs_pkg::*;

    // A stalled result keeps its score
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_total_score))
    // A score request keeps the block busy
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_mode == MODE_SCORE, !o_in_ready)
    // An inlier result always counts at least one inlier
    `ASSERT_NOW(a_cnt, i_clk, i_rst_n, $rose(o_out_valid) && o_point_inlier, o_inlier_total != 17'd0)
    // An inlier never failed cheirality
    `ASSERT_NOW(a_cheir, i_clk, i_rst_n, o_out_valid, !(o_point_inlier && o_cheirality_fail))

endmodule

bind radial_reprojection_scorer rrs_checker u_rrs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .i_mode            (i_mode),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_point_inlier    (o_point_inlier),
    .o_cheirality_fail (o_cheirality_fail),
    .o_total_score     (o_total_score),
    .o_inlier_total    (o_inlier_total)
);

>>> sim/radial_reprojection_scorer_tb.sv
`timescale 1ns / 1ps

module radial_reprojection_scorer_tb;
    import rrs_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CNT_CAP     = 65536;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         SETTLE      = 120;

    typedef struct {
        logic [1:0]         mode;
        logic [1:0]         view;
        logic               row;
        logic signed [31:0] coef [4];
        logic signed [31:0] pt   [3];
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_req;

    typedef struct {
        logic        inlier;
        logic        cheir;
        logic [39:0] residual;
        logic [47:0] score;
        logic [16:0] count;
    } t_res;

    // Scoreboard: tracks camera/point state and queues expected point results
    class point_scoreboard;
        logic signed [31:0] cam [32];
        logic [31:0]        max_err;
        logic [63:0]        part_res;
        logic               pt_ok;
        logic               pt_bad;
        logic [63:0]        score;
        int                 count;
        t_res               pending [$];
        int                 errors;
        int                 results;
        int                 inliers;
        int                 cheir_seen;

        function new();
            foreach (cam[i]) cam[i] = '0;
            max_err  = MAX_ERR_RESET;
            part_res = 0;
            pt_ok    = 1'b1;
            pt_bad   = 1'b0;
            score    = 0;
            count    = 0;
            errors   = 0;
            results  = 0;
            inliers  = 0;
            cheir_seen = 0;
        endfunction

        // p_r = floor(P[r][0..2].X / 2^16) + P[r][3], saturated to 32 bits
        function logic signed [31:0] project(int base, logic signed [31:0] x,
                                             logic signed [31:0] y, logic signed [31:0] z);
            logic signed [127:0] acc;
            logic signed [127:0] c0, c1, c2, c3, xw, yw, zw;
            c0 = cam[base]; c1 = cam[base+1]; c2 = cam[base+2]; c3 = cam[base+3];
            xw = x; yw = y; zw = z;
            acc = c0 * xw + c1 * yw + c2 * zw;
            acc = (acc >>> 16) + c3;
            if (acc > 128'sd2147483647) acc = 128'sd2147483647;
            if (acc < -128'sd2147483648) acc = -128'sd2147483648;
            return acc[31:0];
        endfunction

        function void note_request(t_req rq);
            logic signed [127:0] pu, pv, uw, vw, pp, cr;
            logic [127:0] csq;
            logic [63:0]  r, thr;
            t_res         ex;
            int           base;
            case (rq.mode)
                MODE_LOAD: begin
                    base = rq.view * 8 + rq.row * 4;
                    for (int k = 0; k < 4; k++) cam[base+k] = rq.coef[k];
                end
                MODE_CLEAR: begin
                    score = 0; count = 0;
                    part_res = 0; pt_ok = 1'b1; pt_bad = 1'b0;
                end
                MODE_SCORE: begin
                    base = rq.view * 8;
                    pu = project(base, rq.pt[0], rq.pt[1], rq.pt[2]);
                    pv = project(base + 4, rq.pt[0], rq.pt[1], rq.pt[2]);
                    uw = rq.u; vw = rq.v;
                    if (rq.view == 2'd0) begin
                        part_res = 0; pt_ok = 1'b1; pt_bad = 1'b0;
                    end
                    pp = pu * pu + pv * pv;
                    if (pp == 0) begin
                        r = 64'((uw * uw + vw * vw) >>> 16);
                    end else begin
                        if (pu * uw + pv * vw < 0) pt_bad = 1'b1;
                        cr  = uw * pv - vw * pu;
                        csq = cr * cr;
                        r   = 64'((csq >> 16) / pp);
                    end
                    thr = (64'(max_err) * 64'(max_err)) >> 16;
                    if (!(r < thr)) pt_ok = 1'b0;
                    part_res = part_res + r;
                    if (part_res > 64'(RES_MAX)) part_res = 64'(RES_MAX);
                    if (rq.view == LAST_VIEW) begin
                        ex.inlier = pt_ok && !pt_bad;
                        if (ex.inlier) begin
                            score = score + part_res;
                            if (count < CNT_CAP) count++;
                        end else begin
                            score = score + (thr << 2);
                        end
                        if (score > 64'(SCORE_MAX)) score = 64'(SCORE_MAX);
                        ex.cheir    = pt_bad;
                        ex.residual = part_res[39:0];
                        ex.score    = score[47:0];
                        ex.count    = 17'(count);
                        pending = {pending, ex};
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_res got);
            t_res ex;
            results++;
            if (got.inlier) inliers++;
            if (got.cheir) cheir_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result: no point pending");
                errors++;
                return;
            end
            ex = pending.pop_front();
            if (got.inlier !== ex.inlier) begin
                $error("point_inlier exp %0d got %0d", ex.inlier, got.inlier); errors++;
            end
            if (got.cheir !== ex.cheir) begin
                $error("cheirality_fail exp %0d got %0d", ex.cheir, got.cheir); errors++;
            end
            if (got.residual !== ex.residual) begin
                $error("point_residual exp %h got %h", ex.residual, got.residual); errors++;
            end
            if (got.score !== ex.score) begin
                $error("total_score exp %h got %h", ex.score, got.score); errors++;
            end
            if (got.count !== ex.count) begin
                $error("inlier_total exp %0d got %0d", ex.count, got.count); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = '0;
    logic [1:0]  i_view = '0;
    logic        i_row = 1'b0;
    logic signed [31:0] i_coef0 = '0, i_coef1 = '0, i_coef2 = '0, i_coef3 = '0;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [31:0] i_obs_u = '0, i_obs_v = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_point_inlier;
    logic        o_cheirality_fail;
    logic [39:0] o_point_residual;
    logic [47:0] o_total_score;
    logic [16:0] o_inlier_total;

    point_scoreboard board = new();
    int  idle_phase = 0;   // bit0: sender gaps, bit1: receiver stalls
    int  idle_pct = 55;    // idle share in percent, lower when both sides idle
    int  sent = 0;
    int  idle_cycles = 0;

    always #4 i_clk = ~i_clk;

    radial_reprojection_scorer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_view(i_view), .i_row(i_row),
        .i_coef0(i_coef0), .i_coef1(i_coef1), .i_coef2(i_coef2), .i_coef3(i_coef3),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_obs_u(i_obs_u), .i_obs_v(i_obs_v),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_point_inlier(o_point_inlier), .o_cheirality_fail(o_cheirality_fail),
        .o_point_residual(o_point_residual), .o_total_score(o_total_score),
        .o_inlier_total(o_inlier_total)
    );

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (idle_phase & 2) ? ($urandom_range(99) >= idle_pct) : 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.inlier   = o_point_inlier;
            got.cheir    = o_cheirality_fail;
            got.residual = o_point_residual;
            got.score    = o_total_score;
            got.count    = o_inlier_total;
            board.check_result(got);
        end
    end

    // Watchdog on cycles without any accepted transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(t_req rq);
        i_in_valid <= 1'b1;
        i_mode  <= rq.mode; i_view <= rq.view; i_row <= rq.row;
        i_coef0 <= rq.coef[0]; i_coef1 <= rq.coef[1];
        i_coef2 <= rq.coef[2]; i_coef3 <= rq.coef[3];
        i_point_x <= rq.pt[0]; i_point_y <= rq.pt[1]; i_point_z <= rq.pt[2];
        i_obs_u <= rq.u; i_obs_v <= rq.v;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(rq);
        sent++;
        // sender gap
        if ((idle_phase & 1) && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Wait until every point result is back and the block is quiet
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.max_err = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_req blank_req(logic [1:0] mode, logic [1:0] view);
        t_req rq;
        rq.mode = mode; rq.view = view; rq.row = $urandom_range(1);
        foreach (rq.coef[k]) rq.coef[k] = $urandom;
        foreach (rq.pt[k]) rq.pt[k] = $urandom;
        rq.u = $urandom; rq.v = $urandom;
        return rq;
    endfunction

    function automatic logic signed [31:0] rnd_span(int bits);
        logic signed [31:0] w;
        w = $urandom;
        return w >>> (32 - bits);
    endfunction

    task automatic load_row(int view, int row, logic signed [31:0] c0, logic signed [31:0] c1,
                            logic signed [31:0] c2, logic signed [31:0] c3);
        t_req rq;
        rq = blank_req(MODE_LOAD, 2'(view));
        rq.row = row[0];
        rq.coef[0] = c0; rq.coef[1] = c1; rq.coef[2] = c2; rq.coef[3] = c3;
        send_request(rq);
    endtask

    task automatic load_modest_cameras();
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 2; r++)
                load_row(c, r, rnd_span(19), rnd_span(19), rnd_span(19), rnd_span(22));
    endtask

    // One view of a point; observation mostly follows the projection
    task automatic send_view(int view, logic signed [31:0] p [3]);
        t_req rq;
        logic signed [31:0] pu, pv;
        int kind;
        rq = blank_req(MODE_SCORE, 2'(view));
        rq.pt[0] = p[0]; rq.pt[1] = p[1]; rq.pt[2] = p[2];
        pu = board.project(view * 8, p[0], p[1], p[2]);
        pv = board.project(view * 8 + 4, p[0], p[1], p[2]);
        kind = $urandom_range(99);
        if (kind < 65) begin
            rq.u = pu + rnd_span(15); rq.v = pv + rnd_span(15);
        end else if (kind < 75) begin
            rq.u = -pu; rq.v = -pv;
        end else if (kind < 90) begin
            rq.u = rnd_span(24); rq.v = rnd_span(24);
        end
        send_request(rq);
    endtask

    task automatic send_point(bit wide);
        logic signed [31:0] p [3];
        for (int k = 0; k < 3; k++) p[k] = wide ? $urandom : rnd_span(21);
        for (int v = 0; v < 4; v++) send_view(v, p);
    endtask

    task automatic directed();
        logic signed [31:0] p [3];
        t_req rq;
        // extreme cameras: saturating rows, a zero camera, a unit-ish one
        load_row(0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        load_row(0, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        load_row(2, 0, 32'sh00010000, 0, 0, 0);
        load_row(2, 1, 0, 32'sh00010000, 0, 0);
        load_row(3, 0, rnd_span(32), rnd_span(32), rnd_span(32), rnd_span(32));
        load_row(3, 1, rnd_span(32), rnd_span(32), rnd_span(32), rnd_span(32));
        // point with extreme coordinates and observations (camera 1 projects to zero)
        p[0] = 32'sh7fffffff; p[1] = 32'sh80000000; p[2] = 32'sh7fffffff;
        for (int v = 0; v < 4; v++) begin
            rq = blank_req(MODE_SCORE, 2'(v));
            rq.pt[0] = p[0]; rq.pt[1] = p[1]; rq.pt[2] = p[2];
            rq.u = (v & 1) ? 32'sh80000000 : 32'sh7fffffff;
            rq.v = (v & 1) ? 32'sh7fffffff : 32'sh80000000;
            send_request(rq);
        end
        // unused mode, then a clear in the middle of a point
        send_request(blank_req(MODE_UNUSED, 2'd1));
        send_view(0, p);
        send_view(1, p);
        send_request(blank_req(MODE_CLEAR, 2'd0));
        send_view(2, p);
        send_view(3, p);
        // closing view with no opening view
        send_view(3, p);
        drain();
    endtask

    initial begin
        logic [31:0] settings [5];
        int rounds;
        settings[0] = 32'h0001_0000;
        settings[1] = 32'h0000_0000;
        settings[2] = 32'hffff_ffff;
        settings[3] = 32'h0000_4000;
        settings[4] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_threshold(32'h0002_0000);
        directed();

        for (int s = 0; s < 5; s++) begin
            idle_phase = s % 4;
            idle_pct   = (idle_phase == 3) ? 34 : 55;
            write_threshold(settings[s]);
            load_modest_cameras();
            rounds = 0;
            while (rounds < 75) begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 80) begin
                    send_point($urandom_range(9) == 0);
                end else if (pick < 85) begin
                    load_row($urandom_range(3), $urandom_range(1), rnd_span(19),
                             rnd_span(19), rnd_span(19), rnd_span(22));
                end else if (pick < 88) begin
                    send_request(blank_req(MODE_CLEAR, 2'($urandom_range(3))));
                end else if (pick < 91) begin
                    send_request(blank_req(MODE_UNUSED, 2'($urandom_range(3))));
                end else if (pick < 96) begin
                    // broken sequence: views in random order
                    logic signed [31:0] p [3];
                    for (int k = 0; k < 3; k++) p[k] = rnd_span(21);
                    repeat ($urandom_range(1, 4)) send_view($urandom_range(3), p);
                end else begin
                    send_request(blank_req(MODE_SCORE, 2'($urandom_range(3))));
                end
                rounds++;
            end
            drain();
        end

        $display("Sent %0d requests over 5 thresholds; %0d point results, %0d inliers,",
                 sent, board.results, board.inliers);
        $display("%0d with cheirality failures, under all four idle/stall mixes.",
                 board.cheir_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rrs_pkg.sv
rtl/core/radial_reprojection_scorer.sv
rtl/core/rrs_checker.sv
sim/radial_reprojection_scorer_tb.sv
